[sv/afrd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_pkg: shared types and constants for the API frame deframer
// Holds the transfer payload structs, the status codes, the configuration
// bundle and the framing constants.
// ----------------------------------------------------------------------------
package afrd_pkg;

  localparam int unsigned PosW  = 17;
  localparam int unsigned TickW = 17;

  localparam logic [7:0]      Delim      = 8'h7E;
  localparam logic [7:0]      SumGood    = 8'hFF;
  localparam logic [PosW-1:0] DataStart  = 17'd3;
  localparam logic [15:0]     TimeoutRst = 16'd1000;
  localparam logic [15:0]     MaxPosRst  = 16'd65520;

  // Configuration register indexes.
  localparam logic RegTimeout = 1'b0;
  localparam logic RegMaxPos  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_BUSY    = 3'd1,
    ST_GOOD    = 3'd2,
    ST_BADSUM  = 3'd3,
    ST_LARGE   = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_t;

  typedef enum logic {
    ACT_BYTE = 1'b0,
    ACT_TICK = 1'b1
  } action_t;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] data_byte;
    logic       data_valid;
    logic       is_frame_type;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] max_position;
  } cfg_t;

endpackage

[sv/afrd_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_cfg_regs: configuration registers
// APB-style write and read access to the timeout and maximum position.
// ----------------------------------------------------------------------------
module afrd_cfg_regs
  import afrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TimeoutRst;
      cfg.max_position  <= MaxPosRst;
    end else if (wr_en) begin
      if (paddr[2] == RegTimeout) begin
        cfg.timeout_ticks <= pwdata[15:0];
      end else begin
        cfg.max_position <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == RegTimeout) begin
      prdata = {16'd0, cfg.timeout_ticks};
    end else begin
      prdata = {16'd0, cfg.max_position};
    end
  end

endmodule

[sv/afrd_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afrd_core: frame state and per-item decision logic
// Holds the frame position, length, checksum and tick age, and works out
// the result of one byte or tick in a single pass.
// ----------------------------------------------------------------------------
module afrd_core
  import afrd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [PosW-1:0]  byte_position, byte_position_next;
  logic [15:0]      frame_length, frame_length_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [TickW-1:0] elapsed_ticks, elapsed_ticks_next;

  logic [TickW-1:0] ticks_inc;
  logic [7:0]       sum_add;
  logic [PosW-1:0]  idx;
  logic [PosW-1:0]  idx_inc;
  logic [PosW-1:0]  len_ext;

  assign ticks_inc = (elapsed_ticks != '1) ? elapsed_ticks + 1'b1 : elapsed_ticks;
  assign sum_add   = running_sum + item.rx_byte;
  assign idx       = byte_position - DataStart;
  assign idx_inc   = idx + 1'b1;
  assign len_ext   = {1'b0, frame_length};

  always_comb begin
    byte_position_next   = byte_position;
    frame_length_next    = frame_length;
    running_sum_next     = running_sum;
    elapsed_ticks_next   = elapsed_ticks;
    result.status        = ST_IDLE;
    result.data_byte     = 8'd0;
    result.data_valid    = 1'b0;
    result.is_frame_type = 1'b0;
    result.last          = 1'b0;

    if (item.action == ACT_TICK) begin
      if (byte_position != '0) begin
        elapsed_ticks_next = ticks_inc;
        if (ticks_inc > {1'b0, cfg.timeout_ticks}) begin
          byte_position_next = '0;
          result.status      = ST_TIMEOUT;
        end else begin
          result.status = ST_BUSY;
        end
      end
    end else if (byte_position == '0) begin
      if (item.rx_byte == Delim) begin
        byte_position_next = PosW'(1);
        frame_length_next  = 16'd0;
        running_sum_next   = 8'd0;
        elapsed_ticks_next = '0;
        result.status      = ST_BUSY;
      end
    end else if (byte_position == PosW'(1)) begin
      frame_length_next  = {item.rx_byte, 8'd0};
      byte_position_next = PosW'(2);
      result.status      = ST_BUSY;
    end else if (byte_position == PosW'(2)) begin
      frame_length_next  = {frame_length[15:8], item.rx_byte};
      byte_position_next = DataStart;
      result.status      = ST_BUSY;
    end else if (byte_position > {1'b0, cfg.max_position}) begin
      byte_position_next = '0;
      result.status      = ST_LARGE;
    end else begin
      running_sum_next = sum_add;
      if (idx < len_ext) begin
        result.data_byte     = item.rx_byte;
        result.data_valid    = 1'b1;
        result.is_frame_type = (idx == '0);
        result.last          = (idx_inc == len_ext);
        byte_position_next   = byte_position + 1'b1;
        result.status        = ST_BUSY;
      end else begin
        // Checksum byte closes the frame either way.
        result.status      = (sum_add == SumGood) ? ST_GOOD : ST_BADSUM;
        byte_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      frame_length  <= '0;
      running_sum   <= '0;
      elapsed_ticks <= '0;
    end else if (step) begin
      byte_position <= byte_position_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

endmodule

[sv/api_frame_receive_deframer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_receive_deframer_top: API frame receive deframer
// Hunts for the frame delimiter, takes the 16-bit length, streams the
// frame-data bytes and checks the closing checksum; ticks age open frames.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                      Payload        Direction
//   -------   ----------------------------   ------------   ---------
//   item      item_valid / item_ready        item_t         into block
//   result    result_valid / result_ready    result_t       out of block
//   config    psel/penable/pwrite, pready    paddr, pwdata  into block
//
// Each accepted transfer (a byte or a tick) yields exactly one result
// transfer. The block takes one item per clock cycle while the result
// register is free or being emptied; an accepted item sits in the input
// register while the frame logic works on it, and its result is then
// loaded into the result register. A single-pass update sets that rate.
// Reset (rst, synchronous) returns the deframer to hunting and loads the
// register defaults: timeout 1000 ticks, maximum position 65520.
// When result_ready is low the result register holds, the held item waits in
// the input register, and item_ready drops only once both are full.
//
module api_frame_receive_deframer_top
  import afrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  logic    advance;
  result_t core_result;

  // The held item moves through the frame logic whenever the result
  // register is free or being emptied in this cycle.
  assign advance    = item_q_valid && (!result_valid || result_ready);
  assign item_ready = !item_q_valid || advance;

  afrd_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afrd_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_valid && item_ready) begin
      item_q_valid <= 1'b1;
    end else if (advance) begin
      item_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= core_result;
    end
  end

endmodule

[tb/api_frame_receive_deframer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// api_frame_receive_deframer_top_tb: self-checking bench for the frame deframer
// Feeds byte and tick transfers into the deframer under several register
// settings. A cycle-free model of the frame state predicts every result
// transfer, and a scoreboard compares each result with its prediction.
// ----------------------------------------------------------------------------
module api_frame_receive_deframer_top_tb;
  import afrd_pkg::*;

  // Cycles with no accepted transfer and no register access before the run
  // is declared hung. The longest legal quiet stretch is the deliberate
  // receiver hold-off below, so this leaves a wide margin.
  localparam int IdleLimit     = 5000;
  localparam int HoldCycles    = 400;
  localparam int ItemsPerPhase = 260;

  // --------------------------------------------------------------------------
  // Scoreboard. It keeps its own copy of the frame state and the registers,
  // predicts the result of every accepted item, and checks the results in
  // order against those predictions.
  // --------------------------------------------------------------------------
  class frame_rx_checker;
    logic [15:0] timeout_ticks;
    logic [15:0] max_position;
    logic [15:0] frame_length;
    logic [16:0] byte_position;
    logic [16:0] elapsed_ticks;
    logic [7:0]  running_sum;
    result_t     expected_results[$];
    int          mismatch_count;

    function new();
      timeout_ticks  = TimeoutRst;
      max_position   = MaxPosRst;
      frame_length   = '0;
      byte_position  = '0;
      elapsed_ticks  = '0;
      running_sum    = '0;
      mismatch_count = 0;
    endfunction

    function void report_mismatch(string what, int got, int want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
    endfunction

    // Advances the frame state by one accepted item and queues the result
    // that the item must produce.
    function void take_item(item_t it);
      result_t     res;
      logic [16:0] idx;
      res = '0;
      res.status = ST_IDLE;
      if (it.action == ACT_TICK) begin
        // A tick only matters inside an open frame; the tick count saturates.
        if (byte_position != '0) begin
          if (elapsed_ticks != 17'h1FFFF) elapsed_ticks = elapsed_ticks + 17'd1;
          if (elapsed_ticks > {1'b0, timeout_ticks}) begin
            byte_position = '0;
            res.status = ST_TIMEOUT;
          end else begin
            res.status = ST_BUSY;
          end
        end
      end else if (byte_position == '0) begin
        // Hunting: everything but the delimiter is dropped.
        if (it.rx_byte == Delim) begin
          byte_position = 17'd1;
          frame_length  = '0;
          running_sum   = '0;
          elapsed_ticks = '0;
          res.status    = ST_BUSY;
        end
      end else if (byte_position == 17'd1) begin
        frame_length  = {it.rx_byte, 8'h00};
        byte_position = 17'd2;
        res.status    = ST_BUSY;
      end else if (byte_position == 17'd2) begin
        frame_length[7:0] = it.rx_byte;
        byte_position     = DataStart;
        res.status        = ST_BUSY;
      end else if (byte_position > {1'b0, max_position}) begin
        // The size limit is checked before the byte is used at all.
        byte_position = '0;
        res.status    = ST_LARGE;
      end else begin
        idx = byte_position - DataStart;
        running_sum = running_sum + it.rx_byte;
        if (idx < {1'b0, frame_length}) begin
          res.data_byte     = it.rx_byte;
          res.data_valid    = 1'b1;
          res.is_frame_type = (idx == '0);
          res.last          = ((idx + 17'd1) == {1'b0, frame_length});
          byte_position     = byte_position + 17'd1;
          res.status        = ST_BUSY;
        end else begin
          // Checksum byte: it is part of the sum and closes the frame.
          res.status    = (running_sum == SumGood) ? ST_GOOD : ST_BADSUM;
          byte_position = '0;
        end
      end
      expected_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result status", int'(got.status), -1);
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", int'(got.status), int'(want.status));
      if (got.data_byte !== want.data_byte)
        report_mismatch("data_byte", int'(got.data_byte), int'(want.data_byte));
      if (got.data_valid !== want.data_valid)
        report_mismatch("data_valid", int'(got.data_valid), int'(want.data_valid));
      if (got.is_frame_type !== want.is_frame_type)
        report_mismatch("is_frame_type", int'(got.is_frame_type), int'(want.is_frame_type));
      if (got.last !== want.last)
        report_mismatch("last", int'(got.last), int'(want.last));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block connections. Every input starts from a known value.
  // --------------------------------------------------------------------------
  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [2:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  frame_rx_checker chk = new();

  // Stimulus built ahead of each phase, and the knobs that shape it.
  item_t stim_q[$];
  int    tick_pct;
  int    cur_timeout;
  int    cur_maxpos;
  bit    send_gaps;
  bit    hold_off_req = 1'b0;
  int    idle_cycles  = 0;

  api_frame_receive_deframer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitors. Both channels are sampled at the rising edge, where the values
  // seen are the ones that were set up before the edge. An input transfer is
  // handed to the predictor, a result transfer to the checker.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) chk.take_item(item);
      if (result_valid && result_ready) chk.check_result(result);
    end
  end

  // The watchdog restarts on any transfer or register access. If nothing
  // moves for IdleLimit cycles the block is taken to be hung.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver. It alternates ready bursts with stalls: mostly short ones,
  // occasionally long ones, with some long bursts that have no stall at all.
  // On request it holds off for a long stretch so that the block fills up and
  // has to push back on its input; a request cuts the current burst or stall
  // short so the hold-off starts while the sender is still busy.
  // --------------------------------------------------------------------------
  initial begin
    int burst;
    int gap;
    int r;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      result_ready <= 1'b1;
      repeat (burst) begin
        if (!hold_off_req) @(posedge clk);
      end
      r = $urandom_range(0, 99);
      gap = (r < 40) ? 0 :
            (r < 85) ? $urandom_range(1, 3) :
            (r < 97) ? $urandom_range(4, 12) : $urandom_range(20, 60);
      if (gap != 0 && !hold_off_req) begin
        result_ready <= 1'b0;
        repeat (gap) begin
          if (!hold_off_req) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus building.
  // --------------------------------------------------------------------------
  function automatic void push_byte(logic [7:0] b);
    item_t it;
    it.action  = ACT_BYTE;
    it.rx_byte = b;
    stim_q.push_back(it);
  endfunction

  // The byte field is meaningless on a tick, so it carries random bits.
  function automatic void push_tick();
    item_t it;
    it.action  = ACT_TICK;
    it.rx_byte = 8'($urandom);
    stim_q.push_back(it);
  endfunction

  function automatic void maybe_tick();
    if ($urandom_range(0, 99) < tick_pct) push_tick();
  endfunction

  // One frame with random content. Most lengths are short; some sit right
  // at the size limit, and where the phase closes frames early (small size
  // limit or short timeout) a few carry a random 16-bit length. Very long
  // frames are only partly sent; under a short timeout a run of ticks then
  // abandons them. A truncated frame stops at a random byte and leaves the
  // following bytes to be read as part of it.
  function automatic void push_frame(bit truncate);
    logic [7:0] fb[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         len;
    int         r;
    int         n_data;
    int         limit;
    bit         good;
    r = $urandom_range(0, 99);
    if (r < 60)
      len = $urandom_range(0, 12);
    else if (r < 85)
      len = $urandom_range(13, 40);
    else if (r < 95)
      len = (cur_maxpos < 200) ? cur_maxpos - 4 + $urandom_range(0, 2) : $urandom_range(0, 3);
    else if (cur_maxpos < 200 || cur_timeout <= 20)
      len = $urandom_range(0, 65535);
    else
      len = $urandom_range(41, 100);
    good   = ($urandom_range(0, 3) != 0);
    n_data = (len > 197) ? 197 : len;
    fb.push_back(Delim);
    fb.push_back(8'(len >> 8));
    fb.push_back(8'(len));
    sum = '0;
    for (int i = 0; i < n_data; i++) begin
      b = 8'($urandom);
      sum = sum + b;
      fb.push_back(b);
    end
    if (n_data == len) fb.push_back(good ? 8'(SumGood - sum) : 8'($urandom));
    limit = truncate ? $urandom_range(1, fb.size()) : fb.size();
    for (int i = 0; i < limit; i++) begin
      push_byte(fb[i]);
      maybe_tick();
    end
    if (n_data != len && cur_timeout <= 20) repeat (cur_timeout + 2) push_tick();
  endfunction

  // Sender idle time before an item: mostly none, sometimes a few cycles,
  // rarely a long pause.
  function automatic int sender_gap();
    int r;
    if (!send_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. All inputs change by nonblocking assignment at the rising edge,
  // and each signal gets at most one assignment per edge.
  // --------------------------------------------------------------------------

  // Offers every queued item in turn; valid stays high with a stable payload
  // until the item is taken.
  task automatic send_all();
    item_t it;
    int    gap;
    while (stim_q.size() != 0) begin
      it  = stim_q.pop_front();
      gap = sender_gap();
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      item_valid <= 1'b1;
      item       <= it;
      do @(posedge clk); while (!item_ready);
    end
    item_valid <= 1'b0;
  endtask

  // Register write: a setup cycle, then an access cycle that completes at
  // the edge where pready is high. The predictor takes the new value at the
  // same point.
  task automatic write_reg(logic idx, logic [15:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == RegTimeout) chk.timeout_ticks = val;
    else chk.max_position = val;
    @(posedge clk);
  endtask

  // Every item yields one result, so once nothing is pending both stages
  // of the two-stage pipeline are empty and the block is idle.
  task automatic wait_drained();
    while (chk.expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // One register setting: program it, top up the stimulus with random
  // traffic (well-formed frames mostly, plus truncated frames, stray bytes
  // and tick runs), send it all and wait for every result.
  task automatic run_phase(logic [15:0] tmo, logic [15:0] mpos, int tpct, bit gaps,
                           bit hold);
    int r;
    write_reg(RegTimeout, tmo);
    write_reg(RegMaxPos, mpos);
    cur_timeout = int'(tmo);
    cur_maxpos  = int'(mpos);
    tick_pct    = tpct;
    send_gaps   = gaps;
    while (stim_q.size() < ItemsPerPhase) begin
      r = $urandom_range(0, 99);
      if (r < 75)
        push_frame(1'b0);
      else if (r < 85)
        push_frame(1'b1);
      else if (r < 95)
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
      else
        repeat ($urandom_range(1, 3)) push_tick();
    end
    if (hold) hold_off_req = 1'b1;
    send_all();
    wait_drained();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed checks under the reset defaults. A tick and stray bytes while
    // hunting, a zero-length frame closed by 0xFF, a one-byte frame whose
    // data is the delimiter value (frame type and last on the same byte),
    // and a frame with a tick inside it and a wrong checksum (0x13 after 0xAA, 0x55).
    tick_pct  = 0;
    send_gaps = 1'b1;
    push_tick();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(Delim); push_byte(8'h00); push_byte(8'h00); push_byte(8'hFF);
    push_byte(Delim); push_byte(8'h00); push_byte(8'h01); push_byte(8'h7E);
    push_byte(8'h81);
    push_byte(Delim); push_byte(8'h00); push_byte(8'h02); push_byte(8'hAA);
    push_tick();      push_byte(8'h55); push_byte(8'h13);
    send_all();
    wait_drained();

    // Shortest nonzero timeout: the second tick in a frame abandons it.
    push_byte(Delim); push_tick(); push_tick();
    run_phase(16'd1, 16'hFFFF, 3, 1'b1, 1'b0);

    // Smallest size limit that fits a one-byte frame: its checksum is the last
    // byte allowed, so in a two-byte frame the byte after the data is too large.
    push_byte(Delim); push_byte(8'h00); push_byte(8'h02); push_byte(8'h11);
    push_byte(8'h22);
    run_phase(16'hFFFF, 16'd4, 5, 1'b1, 1'b0);

    // A zero timeout drops an open frame on its first tick.
    run_phase(16'd0, 16'hFFFF, 2, 1'b1, 1'b0);

    // Back-to-back items while the receiver holds off for a long stretch.
    run_phase(16'd20, 16'd40, 8, 1'b0, 1'b1);

    run_phase(16'hFFFF, 16'hFFFF, 5, 1'b1, 1'b0);
    run_phase(TimeoutRst, MaxPosRst, 4, 1'b0, 1'b0);
    run_phase(16'd5, 16'd12, 15, 1'b1, 1'b0);

    if (chk.mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
